FILE: design/ptt_pkg.sv
// Types and constants shared by the periodic timer table.
// Used by ptt_slot_alu and periodic_timer_table_unit; depends on nothing.
`default_nettype none

package ptt_pkg;

    localparam int ID_W    = 8;
    localparam int OWN_W   = 8;
    localparam int CNT_W   = 31;
    localparam int STEP_W  = 16;
    localparam int ACT_W   = 2;
    localparam int KIND_W  = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;

    localparam logic [ACT_W-1:0] ACT_START = 2'd0;
    localparam logic [ACT_W-1:0] ACT_KILL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUIET  = 2'd2;

    // One table slot. The remaining count never leaves 0 .. 2^31-1.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [OWN_W-1:0] owner;
        logic [CNT_W-1:0] remaining;
        logic [CNT_W-1:0] reload;
    } slot_t;

    typedef struct packed {
        logic             id_hit;
        logic             key_hit;
        logic             fire;
        logic [CNT_W-1:0] remaining_next;
    } alu_res_t;

endpackage

`default_nettype wire

FILE: design/periodic_timer_table_unit.sv
// Top level of the periodic timer table: sequencer, slot memory, output register.
// Depends on ptt_pkg and ptt_slot_alu.
//
// Commands arrive on the s_ channel, one item at a time; s_tready is high only
// while the sequencer is idle. Start, kill and tick walk the occupied slots
// through one shared compare/subtract unit, each slot by a memory read, then an
// evaluate and write back. A kill moves the slots after its match down, each by
// a read and then a write, instead of searching them. After each command the
// sequencer returns to idle before it takes the next. Every start, kill and
// clear yields one status item on the m_ channel; a tick yields one item per
// fired timer in slot order, or a single quiet item, with m_tlast on the final
// one. Results pass through an output register, so a new command is taken while
// the last result waits. When the receiver stalls, the sequencer waits at the
// next result it has to hand over. The tick step is written on the cfg_ channel;
// the user must write it only while idle, as the block does not enforce this.
// Reset empties the table and restores a tick step of 100; the slot memory
// itself is not cleared.
`default_nettype none

module periodic_timer_table_unit #(
    parameter int MAX_TIMERS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // timer_id[7:0], owner[15:8], interval[46:16]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // ok[0], fired_id[8:1], fired_owner[16:9]
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import ptt_pkg::*;

    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_EV    = 3'd2;
    localparam logic [2:0] ST_SH_RD = 3'd3;
    localparam logic [2:0] ST_SH_WR = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     idx_plus1;
    logic [STEP_W-1:0] step_reg;

    logic [ACT_W-1:0]  act_reg, act_next;
    logic [ID_W-1:0]   key_id_reg, key_id_next;
    logic [OWN_W-1:0]  key_own_reg, key_own_next;
    logic [CNT_W-1:0]  ivl_reg, ivl_next;

    logic [KIND_W-1:0] pend_kind_reg, pend_kind_next;
    logic              pend_ok_reg, pend_ok_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [OWN_W-1:0]  pend_own_reg, pend_own_next;

    logic              m_valid_reg, m_valid_next;
    logic [KIND_W-1:0] m_kind_reg;
    logic              m_ok_reg;
    logic [ID_W-1:0]   m_id_reg;
    logic [OWN_W-1:0]  m_own_reg;
    logic              m_last_reg;

    slot_t             mem [MAX_TIMERS];
    slot_t             rd_data_reg;
    slot_t             mem_wd;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic              s_accept;
    logic              out_free;
    logic              out_load;
    logic              out_last;
    alu_res_t          alu;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign idx_plus1 = idx_reg + 1'b1;

    ptt_slot_alu u_alu (
        .slot      (rd_data_reg),
        .step      (step_reg),
        .key_id    (key_id_reg),
        .key_owner (key_own_reg),
        .res       (alu)
    );

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        act_next       = act_reg;
        key_id_next    = key_id_reg;
        key_own_next   = key_own_reg;
        ivl_next       = ivl_reg;
        pend_kind_next = pend_kind_reg;
        pend_ok_next   = pend_ok_reg;
        pend_id_next   = pend_id_reg;
        pend_own_next  = pend_own_reg;
        mem_we         = 1'b0;
        mem_wa         = idx_reg[AW-1:0];
        mem_wd         = rd_data_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        out_load       = 1'b0;
        out_last       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    act_next      = s_tuser;
                    key_id_next   = s_tdata[7:0];
                    key_own_next  = s_tdata[15:8];
                    ivl_next      = s_tdata[46:16];
                    idx_next      = '0;
                    pend_ok_next  = 1'b1;
                    pend_id_next  = '0;
                    pend_own_next = '0;
                    if (s_tuser == ACT_TICK) begin
                        pend_kind_next = KIND_QUIET;
                        state_next     = ST_RD;
                    end else if (s_tuser == ACT_CLEAR) begin
                        pend_kind_next = KIND_STATUS;
                        n_next         = '0;
                        state_next     = ST_FIN;
                    end else begin
                        pend_kind_next = KIND_STATUS;
                        state_next     = ST_RD;
                    end
                end
            end
            ST_RD: begin
                if (idx_reg == n_reg) begin
                    // Walked past the last occupied slot.
                    state_next = ST_FIN;
                    if (act_reg == ACT_START) begin
                        if (n_reg == CW'(MAX_TIMERS)) begin
                            pend_ok_next = 1'b0;
                        end else begin
                            mem_we           = 1'b1;
                            mem_wa           = n_reg[AW-1:0];
                            mem_wd.id        = key_id_reg;
                            mem_wd.owner     = key_own_reg;
                            mem_wd.remaining = ivl_reg;
                            mem_wd.reload    = ivl_reg;
                            n_next           = n_reg + 1'b1;
                        end
                    end else if (act_reg == ACT_KILL) begin
                        pend_ok_next = 1'b0;
                    end
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_EV;
                end
            end
            ST_EV: begin
                case (act_reg)
                    ACT_START: begin
                        if (alu.id_hit) begin
                            // Known id: reload count and interval, keep the owner.
                            mem_we           = 1'b1;
                            mem_wd.remaining = ivl_reg;
                            mem_wd.reload    = ivl_reg;
                            state_next       = ST_FIN;
                        end else begin
                            idx_next   = idx_plus1;
                            state_next = ST_RD;
                        end
                    end
                    ACT_KILL: begin
                        if (alu.key_hit) begin
                            state_next = ST_SH_RD;
                        end else begin
                            idx_next   = idx_plus1;
                            state_next = ST_RD;
                        end
                    end
                    default: begin
                        // A new fire hands the previous one out, which then is
                        // known not to be the final item of this tick.
                        if (!(alu.fire && pend_kind_reg == KIND_FIRED && !out_free)) begin
                            mem_we           = 1'b1;
                            mem_wd.remaining = alu.remaining_next;
                            idx_next         = idx_plus1;
                            state_next       = ST_RD;
                            if (alu.fire) begin
                                out_load       = (pend_kind_reg == KIND_FIRED);
                                pend_kind_next = KIND_FIRED;
                                pend_id_next   = rd_data_reg.id;
                                pend_own_next  = rd_data_reg.owner;
                            end
                        end
                    end
                endcase
            end
            ST_SH_RD: begin
                if (idx_plus1 >= n_reg) begin
                    n_next     = n_reg - 1'b1;
                    state_next = ST_FIN;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_plus1[AW-1:0];
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                mem_we     = 1'b1;
                idx_next   = idx_plus1;
                state_next = ST_SH_RD;
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            idx_reg     <= '0;
            step_reg    <= STEP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        key_id_reg    <= key_id_next;
        key_own_reg   <= key_own_next;
        ivl_reg       <= ivl_next;
        pend_kind_reg <= pend_kind_next;
        pend_ok_reg   <= pend_ok_next;
        pend_id_reg   <= pend_id_next;
        pend_own_reg  <= pend_own_next;
        if (out_load) begin
            m_kind_reg <= pend_kind_reg;
            m_ok_reg   <= pend_ok_next;
            m_id_reg   <= pend_id_reg;
            m_own_reg  <= pend_own_reg;
            m_last_reg <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'b0, m_own_reg, m_id_reg, m_ok_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CW'(MAX_TIMERS))
        else $error("entry count exceeds table depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result overwrote an item still waiting at the output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (n_reg != $past(n_reg)) |->
            (n_reg == $past(n_reg) + 1'b1) || (n_reg == $past(n_reg) - 1'b1)
            || (n_reg == '0))
        else $error("entry count moved by more than one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (CW'(mem_wa) < n_reg)
            || ((CW'(mem_wa) == n_reg) && (n_reg < CW'(MAX_TIMERS))))
        else $error("slot write outside the occupied range");

endmodule

`default_nettype wire

FILE: design/ptt_slot_alu.sv
// Shared slot unit: id and owner compare plus the tick subtract and reload.
// Depends on ptt_pkg.
`default_nettype none

module ptt_slot_alu (
    input  wire ptt_pkg::slot_t                   slot,
    input  wire logic [ptt_pkg::STEP_W-1:0]       step,
    input  wire logic [ptt_pkg::ID_W-1:0]         key_id,
    input  wire logic [ptt_pkg::OWN_W-1:0]        key_owner,
    output ptt_pkg::alu_res_t                     res
);
    import ptt_pkg::*;

    logic [CNT_W+1:0] diff;

    assign diff = {2'b00, slot.remaining} - {{(CNT_W+2-STEP_W){1'b0}}, step};

    always_comb begin
        res.id_hit  = (slot.id == key_id);
        res.key_hit = (slot.id == key_id) && (slot.owner == key_owner);
        // A count that drops to zero or below fires and reloads.
        res.fire    = diff[CNT_W+1] || (diff == '0);
        res.remaining_next = res.fire ? slot.reload : diff[CNT_W-1:0];
    end

endmodule

`default_nettype wire
